// File: design/max_heap_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max-heap priority queue
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants shared by the priority queue cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_PEEK   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic  push_en;
    logic  pop_en;
    logic  del_en;
    data_t key;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic ge;
    logic le;
    logic eq;
  } cell_stat_t;

endpackage

`default_nettype wire

// File: design/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted shift array. Holds one value and takes its own,
// its left neighbor's, its right neighbor's or the broadcast key each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mhpq_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire mhpq_pkg::cell_cmd_t  cmd,
  input  wire mhpq_pkg::data_t      prev_value,
  input  wire mhpq_pkg::cell_stat_t prev_stat,
  input  wire mhpq_pkg::data_t      next_value,
  input  wire mhpq_pkg::cell_stat_t next_stat,
  output mhpq_pkg::data_t        value,
  output mhpq_pkg::cell_stat_t   stat
);
  import mhpq_pkg::*;

  `include "max_heap_priority_queue_assert.svh"

  data_t value_r;
  data_t value_nxt;
  logic  valid_r;
  logic  valid_nxt;
  logic  shift_left;

  assign stat.valid = valid_r;
  assign stat.ge    = valid_r && (value_r >= cmd.key);
  assign stat.le    = valid_r && (value_r <= cmd.key);
  assign stat.eq    = valid_r && (value_r == cmd.key);
  assign value      = value_r;

  assign shift_left = cmd.pop_en || (cmd.del_en && stat.le);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (cmd.push_en) begin
      valid_nxt = valid_r || prev_stat.valid;
      if (!stat.ge) begin
        value_nxt = prev_stat.ge ? cmd.key : prev_value;
      end
    end else if (shift_left) begin
      value_nxt = next_value;
      valid_nxt = next_stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // Occupied slots stay packed toward the head of the array.
  `MHPQ_ASSERT_NOW(a_cell_packed, valid_r, prev_stat.valid, "cell occupied after empty slot")
  // Occupied neighbors stay in descending order.
  `MHPQ_ASSERT_NOW(a_cell_sorted, valid_r && next_stat.valid, value_r >= next_value,
    "cell order broken")

endmodule

`default_nettype wire

// File: design/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Bounded priority queue of signed 32-bit values: push, pop maximum, delete
// one occurrence and peek maximum, built as a sorted chain of cells.
// ----------------------------------------------------------------------------
//  Channel  Dir  Ports                                            Accepted when
//  request  in   in_req_type, in_value                            in_valid & in_ready
//  result   out  out_result_value, out_status, out_entry_count    out_valid & out_ready
//
// A request beat is registered, then executed by the whole cell chain at once
// once the result register is free, and its result is registered in turn.
// A new beat is taken every cycle while results are drained every cycle.
// Reset empties every cell and clears the count.
// A stalled result holds execution of the waiting request until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [1:0]        in_req_type,
  input  wire  signed [31:0] in_value,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [1:0]        out_status,
  output logic [6:0]        out_entry_count
);
  import mhpq_pkg::*;

  `include "max_heap_priority_queue_assert.svh"

  logic       req_valid_r;
  logic       req_valid_nxt;
  req_type_t  req_type_r;
  data_t      req_value_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  data_t      out_value_r;
  status_t    out_status_r;
  count_t     count_r;
  count_t     count_nxt;

  logic       exec;
  logic       in_fire;
  logic       empty;
  logic       full;
  logic       found;
  cell_cmd_t  cmd;
  status_t    status;
  data_t      result;

  data_t            cell_value [CAPACITY];
  cell_stat_t       cell_stat  [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] valid_vec;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      data_t      prev_value;
      cell_stat_t prev_stat;
      data_t      next_value;
      cell_stat_t next_stat;

      if (gi == 0) begin : g_head
        assign prev_value = '0;
        assign prev_stat  = '{valid: 1'b1, ge: 1'b1, le: 1'b0, eq: 1'b0};
      end else begin : g_body
        assign prev_value = cell_value[gi-1];
        assign prev_stat  = cell_stat[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign next_value = '0;
        assign next_stat  = '0;
      end else begin : g_mid
        assign next_value = cell_value[gi+1];
        assign next_stat  = cell_stat[gi+1];
      end

      mhpq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .prev_value (prev_value),
        .prev_stat  (prev_stat),
        .next_value (next_value),
        .next_stat  (next_stat),
        .value      (cell_value[gi]),
        .stat       (cell_stat[gi])
      );

      assign eq_vec[gi]    = cell_stat[gi].eq;
      assign valid_vec[gi] = cell_stat[gi].valid;
    end
  endgenerate

  assign in_fire  = in_valid && in_ready;
  assign exec     = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || exec;

  assign empty = !cell_stat[0].valid;
  assign full  = cell_stat[CAPACITY-1].valid;
  assign found = |eq_vec;

  always_comb begin
    cmd         = '0;
    cmd.key     = req_value_r;
    status      = ST_OK;
    result      = '0;
    count_nxt   = count_r;
    case (req_type_r)
      REQ_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.push_en = exec;
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.pop_en = exec;
          result     = cell_value[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          cmd.del_en = exec;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      REQ_PEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          result = cell_value[0];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (in_fire) begin
      req_valid_nxt = 1'b1;
    end else if (exec) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r  <= req_type_t'(in_req_type);
      req_value_r <= in_value;
    end
    if (exec) begin
      out_value_r  <= result;
      out_status_r <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = ENTRY_W'(count_r);

  `MHPQ_ASSERT_NOW(a_count_matches, 1'b1, CNT_W'($countones(valid_vec)) == count_r,
    "entry count disagrees with occupied cells")
  `MHPQ_ASSERT_NEXT(a_push_grows, exec && req_type_r == REQ_PUSH && !full,
    count_r == $past(count_r) + CNT_W'(1), "push did not grow the queue")
  `MHPQ_ASSERT_NOW(a_full_count, out_valid_r && out_status_r == ST_FULL,
    count_r == CNT_W'(CAPACITY), "full status with spare room")
  `MHPQ_ASSERT_NOW(a_empty_count, out_valid_r && out_status_r == ST_EMPTY,
    count_r == '0, "empty status with stored entries")

endmodule

`default_nettype wire
